/* hw/rtl/pa2a_pkg.sv */
`default_nettype none
package pa2a_pkg;

   localparam int DigitsMax = 10;
   localparam int DigitW    = 4;
   localparam int CountW    = 4;
   localparam int FillW     = 6;

   localparam logic [1:0] FuncSdec  = 2'd0;
   localparam logic [1:0] FuncUdec  = 2'd1;
   localparam logic [1:0] FuncHexLo = 2'd2;
   localparam logic [1:0] FuncHexUp = 2'd3;

   localparam logic [7:0] CharZero  = 8'h30;
   localparam logic [7:0] CharSpace = 8'h20;
   localparam logic [7:0] CharMinus = 8'h2D;
   localparam logic [7:0] CharLowA  = 8'h61;
   localparam logic [7:0] CharUpA   = 8'h41;

   localparam logic [31:0] RecipTen = 32'hCCCC_CCCD;

   typedef logic [DigitW-1:0] digit_type;
   typedef digit_type [DigitsMax-1:0] digits_type;

   typedef struct packed {
      digits_type        digits;
      logic [CountW-1:0] count;
      logic              neg;
      logic [FillW-1:0]  fill;
      logic              fill_zero;
      logic              upper;
   } desc_type;

   function automatic logic [7:0] digit_char(input digit_type d, input logic upper);
      logic [7:0] base;
      base = upper ? CharUpA : CharLowA;
      if (d < 4'd10) begin
         digit_char = CharZero + {4'd0, d};
      end else begin
         digit_char = base + {4'd0, d} - 8'd10;
      end
   endfunction

endpackage
`default_nettype wire

/* hw/rtl/pa2a_queue.sv */
`default_nettype none
module pa2a_queue (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               push,
   output logic                    push_ready,
   input  wire pa2a_pkg::desc_type push_desc,
   output logic                    pop_valid,
   input  wire logic               pop,
   output pa2a_pkg::desc_type      pop_desc
);
   import pa2a_pkg::*;

   desc_type   mem_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] cnt_ff, cnt_in;
   logic       do_push, do_pop;

   assign push_ready = (cnt_ff != 2'd2);
   assign pop_valid  = (cnt_ff != 2'd0);
   assign pop_desc   = mem_ff[rd_ptr_ff];
   assign do_push    = push && push_ready;
   assign do_pop     = pop && pop_valid;

   always_comb begin
      wr_ptr_in = do_push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = do_pop ? ~rd_ptr_ff : rd_ptr_ff;
      cnt_in    = cnt_ff + {1'b0, do_push} - {1'b0, do_pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         cnt_ff    <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_desc;
      end
   end

endmodule
`default_nettype wire

/* hw/rtl/pa2a_front.sv */
`default_nettype none
module pa2a_front #(
   parameter int MAX_WIDTH = 32
) (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          req_tvalid,
   output logic               req_tready,
   input  wire logic [1:0]    req_func,
   input  wire logic [31:0]   req_value,
   input  wire logic          req_fill_zero,
   input  wire logic [5:0]    req_field_width,
   output logic               push,
   input  wire logic          push_ready,
   output pa2a_pkg::desc_type push_desc
);
   import pa2a_pkg::*;

   typedef enum logic [1:0] {ST_IDLE, ST_CONV, ST_PUSH} state_type;

   localparam logic [6:0] MaxW = 7'(MAX_WIDTH);

   state_type         state_ff, state_in;
   logic [31:0]       mag_ff, mag_in;
   logic              hex_ff, hex_in;
   logic              upper_ff, upper_in;
   logic              neg_ff, neg_in;
   logic              zero_ff, zero_in;
   logic [FillW-1:0]  width_ff, width_in;
   logic [CountW-1:0] count_ff, count_in;
   digits_type        digits_ff, digits_in;

   logic [63:0]       prod;
   logic [31:0]       quot;
   logic [31:0]       rem;
   digit_type         digit;
   logic [31:0]       next_mag;
   logic [4:0]        len;
   logic              take;

   assign req_tready = (state_ff == ST_IDLE);
   assign take       = req_tvalid && req_tready;
   assign push       = (state_ff == ST_PUSH);

   assign prod     = {32'd0, mag_ff} * {32'd0, RecipTen};
   assign quot     = {3'd0, prod[63:35]};
   assign rem      = mag_ff - (quot << 3) - (quot << 1);
   assign digit    = hex_ff ? mag_ff[3:0] : rem[3:0];
   assign next_mag = hex_ff ? {4'd0, mag_ff[31:4]} : quot;

   assign len = {1'b0, count_ff} + {4'd0, neg_ff};

   always_comb begin
      push_desc.digits    = digits_ff;
      push_desc.count     = count_ff;
      push_desc.neg       = neg_ff;
      push_desc.fill      = ({1'b0, width_ff} > {1'b0, len}) ?
                            (width_ff - {1'b0, len}) : '0;
      push_desc.fill_zero = zero_ff;
      push_desc.upper     = upper_ff;
   end

   always_comb begin
      state_in  = state_ff;
      mag_in    = mag_ff;
      hex_in    = hex_ff;
      upper_in  = upper_ff;
      neg_in    = neg_ff;
      zero_in   = zero_ff;
      width_in  = width_ff;
      count_in  = count_ff;
      digits_in = digits_ff;
      case (state_ff)
         ST_IDLE: begin
            if (take) begin
               neg_in   = (req_func == FuncSdec) && req_value[31];
               mag_in   = neg_in ? (32'd0 - req_value) : req_value;
               hex_in   = (req_func == FuncHexLo) || (req_func == FuncHexUp);
               upper_in = (req_func == FuncHexUp);
               zero_in  = req_fill_zero;
               width_in = ({1'b0, req_field_width} > MaxW) ? MaxW[5:0] : req_field_width;
               count_in = '0;
               state_in = ST_CONV;
            end
         end
         ST_CONV: begin
            digits_in = {digits_ff[DigitsMax-2:0], digit};
            count_in  = count_ff + 4'd1;
            mag_in    = next_mag;
            if (next_mag == 32'd0) begin
               state_in = ST_PUSH;
            end
         end
         ST_PUSH: begin
            if (push_ready) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
      mag_ff    <= mag_in;
      hex_ff    <= hex_in;
      upper_ff  <= upper_in;
      neg_ff    <= neg_in;
      zero_ff   <= zero_in;
      width_ff  <= width_in;
      count_ff  <= count_in;
      digits_ff <= digits_in;
   end

endmodule
`default_nettype wire

/* hw/rtl/pa2a_back.sv */
`default_nettype none
module pa2a_back (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               pop_valid,
   output logic                    pop,
   input  wire pa2a_pkg::desc_type pop_desc,
   output logic                    rsp_tvalid,
   input  wire logic               rsp_tready,
   output logic [7:0]              rsp_tdata,
   output logic                    rsp_tlast
);
   import pa2a_pkg::*;

   logic              busy_ff, busy_in;
   digits_type        digits_ff, digits_in;
   logic [CountW-1:0] count_ff, count_in;
   logic              neg_ff, neg_in;
   logic [FillW-1:0]  fill_ff, fill_in;
   logic              zero_ff, zero_in;
   logic              upper_ff, upper_in;
   logic              vld_ff, vld_in;
   logic [7:0]        ch_ff, ch_in;
   logic              last_ff, last_in;
   logic              adv;
   logic              is_last;

   assign pop        = !busy_ff && pop_valid;
   assign adv        = busy_ff && (!vld_ff || rsp_tready);
   assign is_last    = (fill_ff == '0) && !neg_ff && (count_ff == 4'd1);
   assign rsp_tvalid = vld_ff;
   assign rsp_tdata  = ch_ff;
   assign rsp_tlast  = last_ff;

   always_comb begin
      busy_in   = busy_ff;
      digits_in = digits_ff;
      count_in  = count_ff;
      neg_in    = neg_ff;
      fill_in   = fill_ff;
      zero_in   = zero_ff;
      upper_in  = upper_ff;
      vld_in    = vld_ff && !rsp_tready;
      ch_in     = ch_ff;
      last_in   = last_ff;
      if (pop) begin
         busy_in   = 1'b1;
         digits_in = pop_desc.digits;
         count_in  = pop_desc.count;
         neg_in    = pop_desc.neg;
         fill_in   = pop_desc.fill;
         zero_in   = pop_desc.fill_zero;
         upper_in  = pop_desc.upper;
      end else if (adv) begin
         vld_in  = 1'b1;
         last_in = is_last;
         if (fill_ff != '0) begin
            ch_in   = zero_ff ? CharZero : CharSpace;
            fill_in = fill_ff - 6'd1;
         end else if (neg_ff) begin
            ch_in  = CharMinus;
            neg_in = 1'b0;
         end else begin
            ch_in     = digit_char(digits_ff[0], upper_ff);
            digits_in = digits_type'(digits_ff >> DigitW);
            count_in  = count_ff - 4'd1;
         end
         if (is_last) begin
            busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         vld_ff  <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         vld_ff  <= vld_in;
      end
      digits_ff <= digits_in;
      count_ff  <= count_in;
      neg_ff    <= neg_in;
      fill_ff   <= fill_in;
      zero_ff   <= zero_in;
      upper_ff  <= upper_in;
      ch_ff     <= ch_in;
      last_ff   <= last_in;
   end

endmodule
`default_nettype wire

/* hw/rtl/padded_integer_to_ascii.sv */
`default_nettype none
// Formats a 32-bit value as a run of ASCII characters: signed or unsigned
// decimal, or lower/upper case hex, left-padded with spaces or zeros up to
// field_width (saturated at MAX_WIDTH); zero fill goes before the '-' sign.
// Each input item yields one output item per character, tlast on the final
// one. The front converts one digit per cycle (decimal through a 32x32
// reciprocal multiply, hex by shifting) and takes a new item only once
// the last one is queued; a two-entry queue decouples it from the back,
// which sends one character per cycle while rsp_tready holds and loads
// the next item only after the final character of the last one.
module padded_integer_to_ascii #(
   parameter int MAX_WIDTH = 32
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [39:0] req_tdata,  // value[31:0], fill_zero[32], field_width[38:33], zero
   input  wire logic [1:0]  req_tuser,  // func[1:0]
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [7:0]       rsp_tdata,  // ch[7:0]
   output logic             rsp_tlast
);
   import pa2a_pkg::*;

   logic     q_push;
   logic     q_push_ready;
   desc_type q_push_desc;
   logic     q_pop_valid;
   logic     q_pop;
   desc_type q_pop_desc;

   pa2a_front #(
      .MAX_WIDTH(MAX_WIDTH)
   ) u_front (
      .clock           (clock),
      .reset           (reset),
      .req_tvalid      (req_tvalid),
      .req_tready      (req_tready),
      .req_func        (req_tuser),
      .req_value       (req_tdata[31:0]),
      .req_fill_zero   (req_tdata[32]),
      .req_field_width (req_tdata[38:33]),
      .push            (q_push),
      .push_ready      (q_push_ready),
      .push_desc       (q_push_desc)
   );

   pa2a_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (q_push),
      .push_ready (q_push_ready),
      .push_desc  (q_push_desc),
      .pop_valid  (q_pop_valid),
      .pop        (q_pop),
      .pop_desc   (q_pop_desc)
   );

   pa2a_back u_back (
      .clock      (clock),
      .reset      (reset),
      .pop_valid  (q_pop_valid),
      .pop        (q_pop),
      .pop_desc   (q_pop_desc),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

   a_pop_needs_entry: assert property (@(posedge clock) disable iff (reset)
      q_pop |-> q_pop_valid)
      else $error("back took an item from an empty queue");

   a_pushed_digits: assert property (@(posedge clock) disable iff (reset)
      q_push |-> (q_push_desc.count != 4'd0) && (q_push_desc.count <= 4'd10))
      else $error("item queued with a bad digit count");

   a_no_nul_char: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tdata != 8'd0))
      else $error("NUL character sent");

endmodule
`default_nettype wire
